FILE: hdl/tlvfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvfe_pkg
// Shared types and constants for the ASCII TLV tag search block.
// ----------------------------------------------------------------------------
package tlvfe_pkg;

   localparam int BYTE_W   = 8;
   localparam int TAG_W    = 24;
   localparam int VLEN_W   = 10;
   localparam int STATUS_W = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_VALUE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [VLEN_W-1:0]   value_length;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/tlvfe_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvfe_parse
// Input word register and the per-byte TLV walk: total length, tag compare,
// element length, skip or emit. Produces at most one result per word.
// ----------------------------------------------------------------------------
module tlvfe_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire logic [tlvfe_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic                          buffer_start,
   input  wire logic [tlvfe_pkg::TAG_W-1:0]   wanted_tag,
   input  wire logic                          out_free,
   output      logic                          res_load,
   output      tlvfe_pkg::result_type         res
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_TOTAL = 3'd1;
   localparam logic [2:0] PH_TAG   = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_SKIP  = 3'd4;
   localparam logic [2:0] PH_EMIT  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   // input word register
   logic                         word_valid_ff, word_valid_in;
   logic [tlvfe_pkg::BYTE_W-1:0] word_byte_ff;
   logic                         word_start_ff;

   // walk state
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  digit_index_ff, digit_index_in;
   logic [13:0] total_length_ff, total_length_in;
   logic [13:0] walk_offset_ff, walk_offset_in;
   logic [9:0]  element_length_ff, element_length_in;
   logic [9:0]  bytes_left_ff, bytes_left_in;
   logic        tag_equal_ff, tag_equal_in;
   logic        digits_stopped_ff, digits_stopped_in;

   logic advance;

   // state seen by this word after a possible restart
   logic [2:0]  eff_phase;
   logic [1:0]  eff_index;
   logic [13:0] eff_total;
   logic [13:0] eff_walk;
   logic        eff_stopped;

   logic        is_digit;
   logic [3:0]  digit;
   logic [13:0] total_next;
   logic [9:0]  elen_next;
   logic [9:0]  bytes_dec;
   logic [7:0]  want;
   logic        do_boundary;
   logic [13:0] bnd_walk;
   logic [13:0] bnd_total;

   function automatic logic [13:0] times10_14(input logic [13:0] v);
      return {v[10:0], 3'b000} + {v[12:0], 1'b0};
   endfunction

   function automatic logic [9:0] times10_10(input logic [9:0] v);
      return {v[6:0], 3'b000} + {v[8:0], 1'b0};
   endfunction

   assign advance  = word_valid_ff && out_free;
   assign in_ready = !word_valid_ff || advance;

   always_comb begin
      word_valid_in = word_valid_ff;
      if (in_valid && in_ready) begin
         word_valid_in = 1'b1;
      end else if (advance) begin
         word_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
      if (in_valid && in_ready) begin
         word_byte_ff  <= data_byte;
         word_start_ff <= buffer_start;
      end
   end

   always_comb begin
      eff_phase   = phase_ff;
      eff_index   = digit_index_ff;
      eff_total   = total_length_ff;
      eff_walk    = walk_offset_ff;
      eff_stopped = digits_stopped_ff;
      if (word_start_ff) begin
         eff_phase   = PH_TOTAL;
         eff_index   = 2'd0;
         eff_total   = 14'd0;
         eff_walk    = 14'd0;
         eff_stopped = 1'b0;
      end

      is_digit = (word_byte_ff >= 8'h30) && (word_byte_ff <= 8'h39);
      digit    = word_byte_ff[3:0];

      total_next = eff_total;
      if (!eff_stopped && is_digit) begin
         total_next = times10_14(eff_total) + 14'(digit);
      end
      elen_next = element_length_ff;
      if (!eff_stopped && is_digit) begin
         elen_next = times10_10(element_length_ff) + 10'(digit);
      end
      bytes_dec = bytes_left_ff - 10'd1;

      case (eff_index)
         2'd0:    want = wanted_tag[23:16];
         2'd1:    want = wanted_tag[15:8];
         2'd2:    want = wanted_tag[7:0];
         default: want = 8'h00;
      endcase

      phase_in          = eff_phase;
      digit_index_in    = eff_index;
      total_length_in   = eff_total;
      walk_offset_in    = eff_walk;
      element_length_in = element_length_ff;
      bytes_left_in     = bytes_left_ff;
      tag_equal_in      = tag_equal_ff;
      digits_stopped_in = eff_stopped;
      do_boundary       = 1'b0;
      bnd_walk          = eff_walk;
      bnd_total         = eff_total;
      res_load          = 1'b0;
      res               = '0;

      unique case (eff_phase)
         PH_TOTAL: begin
            total_length_in   = total_next;
            digits_stopped_in = eff_stopped || !is_digit;
            if (eff_index == 2'd3) begin
               do_boundary = 1'b1;
               bnd_total   = total_next;
            end else begin
               digit_index_in = eff_index + 2'd1;
            end
         end
         PH_TAG: begin
            if (want != word_byte_ff) begin
               tag_equal_in = 1'b0;
            end
            if (eff_index >= 2'd2) begin
               phase_in          = PH_LEN;
               digit_index_in    = 2'd0;
               element_length_in = 10'd0;
               digits_stopped_in = 1'b0;
            end else begin
               digit_index_in = eff_index + 2'd1;
            end
         end
         PH_LEN: begin
            element_length_in = elen_next;
            digits_stopped_in = eff_stopped || !is_digit;
            if (eff_index < 2'd2) begin
               digit_index_in = eff_index + 2'd1;
            end else begin
               digit_index_in = 2'd0;
               if (tag_equal_ff) begin
                  if (elen_next == 10'd0) begin
                     phase_in         = PH_DONE;
                     res_load         = 1'b1;
                     res.status       = tlvfe_pkg::STATUS_EMPTY;
                     res.last         = 1'b1;
                  end else begin
                     phase_in      = PH_EMIT;
                     bytes_left_in = elen_next;
                  end
               end else begin
                  // element header is six characters
                  walk_offset_in = eff_walk + 14'(elen_next) + 14'd6;
                  if (elen_next == 10'd0) begin
                     do_boundary = 1'b1;
                     bnd_walk    = eff_walk + 14'd6;
                  end else begin
                     phase_in      = PH_SKIP;
                     bytes_left_in = elen_next;
                  end
               end
            end
         end
         PH_SKIP: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == 10'd0) begin
               do_boundary = 1'b1;
            end
         end
         PH_EMIT: begin
            bytes_left_in    = bytes_dec;
            res_load         = 1'b1;
            res.out_byte     = word_byte_ff;
            res.value_length = element_length_ff;
            res.status       = tlvfe_pkg::STATUS_VALUE;
            if (bytes_dec == 10'd0) begin
               phase_in = PH_DONE;
               res.last = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // element boundary: end of buffer or start of the next tag
      if (do_boundary) begin
         if (bnd_walk >= bnd_total) begin
            phase_in   = PH_DONE;
            res_load   = 1'b1;
            res.status = tlvfe_pkg::STATUS_NOT_FOUND;
            res.last   = 1'b1;
         end else begin
            phase_in       = PH_TAG;
            digit_index_in = 2'd0;
            tag_equal_in   = 1'b1;
         end
      end

      if (!advance) begin
         res_load = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         digit_index_ff    <= 2'd0;
         total_length_ff   <= 14'd0;
         walk_offset_ff    <= 14'd0;
         element_length_ff <= 10'd0;
         bytes_left_ff     <= 10'd0;
         tag_equal_ff      <= 1'b0;
         digits_stopped_ff <= 1'b0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         digit_index_ff    <= digit_index_in;
         total_length_ff   <= total_length_in;
         walk_offset_ff    <= walk_offset_in;
         element_length_ff <= element_length_in;
         bytes_left_ff     <= bytes_left_in;
         tag_equal_ff      <= tag_equal_in;
         digits_stopped_ff <= digits_stopped_in;
      end
   end

   a_final_marked: assert property (@(posedge clock) disable iff (reset)
      (res_load && res.status != tlvfe_pkg::STATUS_VALUE) |-> res.last)
      else $error("empty or not-found result without last");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EMIT) |-> (bytes_left_ff != 10'd0))
      else $error("emit phase with no bytes left");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (res_load && res.last) |=> (phase_ff == PH_DONE))
      else $error("walk not done after final result");

   a_len_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN || phase_ff == PH_TAG) |-> (digit_index_ff != 2'd3))
      else $error("digit index out of range in tag or length field");

endmodule
`default_nettype wire

FILE: hdl/tlvfe_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvfe_out
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module tlvfe_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  res_load,
   input  wire tlvfe_pkg::result_type res,
   output      logic                  out_free,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      tlvfe_pkg::result_type rsp
);

   logic                  valid_ff, valid_in;
   tlvfe_pkg::result_type data_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (res_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (res_load) begin
         data_ff <= res;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !res_load)
      else $error("result word overwritten while waiting");

endmodule
`default_nettype wire

FILE: hdl/tlv_field_extract.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_field_extract
// Searches an ASCII TLV buffer, one byte per word, for the configured tag and
// returns the matched value bytes, a found-empty word or a not-found word.
// ----------------------------------------------------------------------------
// path: an accepted byte goes to the input word register, and any result word
//   for it is then loaded into the result register, where it can be taken
// throughput: one byte per cycle; a result word waiting on rsp_ready holds
//   the walk and the input word register
// reset: walk returns to idle, waiting for a buffer start; wanted_tag clears
//   to zero; both word registers empty
module tlv_field_extract (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [tlvfe_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                            req_buffer_start,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [tlvfe_pkg::BYTE_W-1:0]    rsp_out_byte,
   output      logic [tlvfe_pkg::VLEN_W-1:0]    rsp_value_length,
   output      logic [tlvfe_pkg::STATUS_W-1:0]  rsp_status,
   output      logic                            rsp_last,
   input  wire logic                            csr_wr_en,
   input  wire logic [tlvfe_pkg::TAG_W-1:0]     csr_wr_data
);

   logic [tlvfe_pkg::TAG_W-1:0] wanted_tag_ff;
   logic                        out_free;
   logic                        res_load;
   tlvfe_pkg::result_type       res;
   tlvfe_pkg::result_type       rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_tag_ff <= '0;
      end else if (csr_wr_en) begin
         wanted_tag_ff <= csr_wr_data;
      end
   end

   tlvfe_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .data_byte    (req_data_byte),
      .buffer_start (req_buffer_start),
      .wanted_tag   (wanted_tag_ff),
      .out_free     (out_free),
      .res_load     (res_load),
      .res          (res)
   );

   tlvfe_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte     = rsp.out_byte;
   assign rsp_value_length = rsp.value_length;
   assign rsp_status       = rsp.status;
   assign rsp_last         = rsp.last;

endmodule
`default_nettype wire

FILE: verif/tb_tlv_field_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlv_field_extract
// Self-checking bench for the ASCII TLV tag search. Feeds directed and random
// TLV buffers (well formed, damaged, truncated, plus noise) under random
// idling on both channels, and compares every result word with a cycle-free
// model of the tag walk kept in a small scoreboard class.
// ----------------------------------------------------------------------------

typedef enum logic [2:0] {
   WALK_IDLE, WALK_TOTAL, WALK_TAG, WALK_LEN, WALK_SKIP, WALK_EMIT, WALK_DONE
} walk_phase_type;

class tag_search_tracker;
   logic [tlvfe_pkg::TAG_W-1:0] wanted;
   walk_phase_type              walk;
   int unsigned                 digit_idx;
   int unsigned                 total_len;
   int unsigned                 walk_off;
   int unsigned                 elem_len;
   int unsigned                 left;
   bit                          tag_match;
   bit                          digits_done;
   tlvfe_pkg::result_type       expected_words[$];
   int unsigned                 errors;

   function new();
      wanted      = '0;
      walk        = WALK_IDLE;
      digit_idx   = 0;
      total_len   = 0;
      walk_off    = 0;
      elem_len    = 0;
      left        = 0;
      tag_match   = 1'b0;
      digits_done = 1'b0;
      errors      = 0;
   endfunction

   function void set_tag(logic [tlvfe_pkg::TAG_W-1:0] t);
      wanted = t;
   endfunction

   function int pending();
      return expected_words.size();
   endfunction

   // decimal field read like atoi: stops for good at the first non-digit
   function int unsigned accumulate(int unsigned acc, logic [7:0] b);
      if (digits_done)
         return acc;
      if (b < "0" || b > "9") begin
         digits_done = 1'b1;
         return acc;
      end
      return acc * 10 + (b - "0");
   endfunction

   function void push_result(logic [7:0] b, int unsigned len,
                             logic [tlvfe_pkg::STATUS_W-1:0] st, logic fin);
      tlvfe_pkg::result_type w;
      w.out_byte     = b;
      w.value_length = len[tlvfe_pkg::VLEN_W-1:0];
      w.status       = st;
      w.last         = fin;
      expected_words.push_back(w);
   endfunction

   // element boundary: walk reached or passed the total, or a new tag begins
   function void reach_boundary();
      if (walk_off >= total_len) begin
         walk = WALK_DONE;
         push_result(8'h00, 0, tlvfe_pkg::STATUS_NOT_FOUND, 1'b1);
      end else begin
         walk      = WALK_TAG;
         digit_idx = 0;
         tag_match = 1'b1;
      end
   endfunction

   // returns 1 when the byte takes part in a buffer walk
   function bit note_byte(logic [7:0] b, logic first);
      logic [7:0] want;
      if (first) begin
         walk        = WALK_TOTAL;
         digit_idx   = 0;
         total_len   = 0;
         walk_off    = 0;
         digits_done = 1'b0;
      end
      case (walk)
         WALK_TOTAL: begin
            total_len = accumulate(total_len, b);
            if (digit_idx >= 3)
               reach_boundary();
            else
               digit_idx++;
         end
         WALK_TAG: begin
            want = 8'(wanted >> (16 - 8 * digit_idx));
            if (want != b)
               tag_match = 1'b0;
            if (digit_idx >= 2) begin
               walk        = WALK_LEN;
               digit_idx   = 0;
               elem_len    = 0;
               digits_done = 1'b0;
            end else begin
               digit_idx++;
            end
         end
         WALK_LEN: begin
            elem_len = accumulate(elem_len, b);
            if (digit_idx < 2) begin
               digit_idx++;
            end else begin
               digit_idx = 0;
               if (tag_match) begin
                  if (elem_len == 0) begin
                     walk = WALK_DONE;
                     push_result(8'h00, 0, tlvfe_pkg::STATUS_EMPTY, 1'b1);
                  end else begin
                     walk = WALK_EMIT;
                     left = elem_len;
                  end
               end else begin
                  walk_off += 6 + elem_len;
                  if (elem_len == 0) begin
                     reach_boundary();
                  end else begin
                     walk = WALK_SKIP;
                     left = elem_len;
                  end
               end
            end
         end
         WALK_SKIP: begin
            left--;
            if (left == 0)
               reach_boundary();
         end
         WALK_EMIT: begin
            left--;
            push_result(b, elem_len, tlvfe_pkg::STATUS_VALUE, left == 0);
            if (left == 0)
               walk = WALK_DONE;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function void check_word(tlvfe_pkg::result_type got);
      tlvfe_pkg::result_type want;
      if (expected_words.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected word: byte %02h len %0d status %0d last %0b",
                     got.out_byte, got.value_length, got.status, got.last);
         return;
      end
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte || got.value_length !== want.value_length ||
          got.status !== want.status || got.last !== want.last) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected byte %02h len %0d status %0d last %0b, ",
                     want.out_byte, want.value_length, want.status, want.last,
                     "got byte %02h len %0d status %0d last %0b",
                     got.out_byte, got.value_length, got.status, got.last);
      end
   endfunction
endclass

module tb_tlv_field_extract;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [tlvfe_pkg::BYTE_W-1:0]   req_data_byte;
   logic                           req_buffer_start;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [tlvfe_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic [tlvfe_pkg::VLEN_W-1:0]   rsp_value_length;
   logic [tlvfe_pkg::STATUS_W-1:0] rsp_status;
   logic                           rsp_last;
   logic                           csr_wr_en;
   logic [tlvfe_pkg::TAG_W-1:0]    csr_wr_data;

   tag_search_tracker tracker;
   logic [7:0]        frame_q[$];
   int                tx_idle_pct;
   int                rx_idle_pct;
   int                items;
   bit                hold_go;
   bit                hold_used;

   tlv_field_extract uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_buffer_start (req_buffer_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_value_length (rsp_value_length),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // all tasks below are entered and left just after a falling edge
   task automatic send_byte(logic [7:0] d, logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_buffer_start <= first;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      void'(tracker.note_byte(d, first));
      items++;
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit first);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], first && i == 0);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == 0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
      // room for a word still in flight after a byte with no result
      repeat (6) @(negedge clock);
   endtask

   task automatic write_tag(logic [tlvfe_pkg::TAG_W-1:0] t);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_tag(t);
   endtask

   // decimal field, now and then with digits swapped for random bytes
   function automatic void push_number(int unsigned v, int unsigned digits, int bad_pct);
      int unsigned div;
      div = 1;
      repeat (digits - 1) div *= 10;
      for (int i = 0; i < digits; i++) begin
         if ($urandom_range(99) < bad_pct)
            frame_q.push_back(8'($urandom));
         else
            frame_q.push_back(8'h30 + 8'((v / div) % 10));
         div /= 10;
      end
   endfunction

   function automatic void make_buffer(logic [tlvfe_pkg::TAG_W-1:0] tag);
      int unsigned lens[4];
      int unsigned n_elem;
      int unsigned sum;
      int unsigned total;
      int unsigned pick;
      int unsigned cut;
      logic [tlvfe_pkg::TAG_W-1:0] etag;
      frame_q.delete();
      n_elem = $urandom_range(0, 4);
      sum = 0;
      for (int i = 0; i < n_elem; i++) begin
         pick = $urandom_range(99);
         if (pick < 15)
            lens[i] = 0;
         else if (pick < 85)
            lens[i] = $urandom_range(1, 9);
         else if (pick < 98)
            lens[i] = $urandom_range(10, 40);
         else
            lens[i] = $urandom_range(100, 999);
         sum += 6 + lens[i];
      end
      pick = $urandom_range(99);
      if (pick < 70)
         total = sum;
      else if (pick < 80)
         total = $urandom_range(0, sum);
      else if (pick < 90)
         total = sum + $urandom_range(1, 50);
      else
         total = $urandom_range(0, 9999);
      if (total > 9999)
         total = 9999;
      push_number(total, 4, 5);
      for (int i = 0; i < n_elem; i++) begin
         pick = $urandom_range(99);
         etag = tag;
         if (pick >= 60)
            etag = 24'($urandom);
         else if (pick >= 45)
            etag[8 * $urandom_range(2) +: 8] = 8'($urandom);
         for (int k = 2; k >= 0; k--)
            frame_q.push_back(etag[8 * k +: 8]);
         push_number(lens[i], 3, 6);
         repeat (lens[i]) frame_q.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
      // some buffers are cut short by the next buffer start
      if ($urandom_range(9) == 0 && frame_q.size() > 1) begin
         cut = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > cut)
            void'(frame_q.pop_back());
      end
   endfunction

   initial begin : result_sink
      int hold_left;
      tlvfe_pkg::result_type got;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_out_byte, rsp_value_length, rsp_status, rsp_last};
            tracker.check_word(got);
         end
         @(negedge clock);
         if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      logic [tlvfe_pkg::TAG_W-1:0] tag;
      int target;
      tracker          = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_buffer_start = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      tx_idle_pct      = 38;
      rx_idle_pct      = 55;
      items            = 0;
      hold_go          = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_tag(24'h414243);
      send_byte(8'hFF, 1'b0);            // idle, no buffer yet
      send_text("0000", 1'b1);           // zero total
      send_byte(8'h00, 1'b0);            // after the decision
      send_text("0001XYZ000", 1'b1);     // walk passes the total
      send_text("7", 1'b1);              // abandoned by the restart below
      send_text("0001ABC0x5", 1'b1);     // length stops at the x: found empty
      send_text("0001ABC002", 1'b1);     // value runs past the total
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);

      for (int ph = 0; ph < 3; ph++) begin
         wait_drained();
         case (ph)
            0: tag = 24'hFFFFFF;
            1: begin
               tag         = 24'h000000;
               tx_idle_pct = 55;
               rx_idle_pct = 38;
            end
            default: begin
               tag         = {8'h41 + 8'($urandom_range(25)), 8'h41 + 8'($urandom_range(25)),
                              8'h30 + 8'($urandom_range(9))};
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         write_tag(tag);
         if (ph == 2) begin
            // long receiver stall on a long match so the input backs up
            hold_go = 1'b1;
            frame_q.delete();
            push_number(46, 4, 0);
            for (int k = 2; k >= 0; k--)
               frame_q.push_back(tag[8 * k +: 8]);
            push_number(40, 3, 0);
            repeat (40) frame_q.push_back(8'($urandom));
            send_frame();
         end
         target = items + 270;
         while (items < target) begin
            if ($urandom_range(99) < 8) begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom), $urandom_range(7) == 0);
            end else begin
               make_buffer(tag);
               send_frame();
            end
            if ($urandom_range(19) == 0)
               wait_drained();
         end
      end

      wait_drained();
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
